FILE: rtl/potb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_pkg: shared types and constants of the order book matcher
// codes, payload structs and controller/datapath command and status groups
// ----------------------------------------------------------------------------
package potb_pkg;

  localparam int unsigned SideDepthDef = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_REDUCE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_QTY  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NOT_RED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_buy;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] order_id;
  } req_t;

  typedef struct packed {
    logic        is_trade;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [31:0] trade_price;
    logic [31:0] trade_qty;
    logic [63:0] stamp;
    logic [31:0] assigned_id;
    logic [31:0] remaining_qty;
    logic [2:0]  status;
    logic        last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_start; // restart slot scan
    logic scan_step;  // examine one slot per side
    logic take_ids;   // consume id and stamp
    logic fill;       // apply fill at best, emit trade
    logic rest;       // write remainder into free slot
    logic modify;     // apply cancel or reduce
    logic ack;        // emit acknowledgement
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic        scan_done;
    logic        best_found;
    logic        free_found;
    logic        id_found;
    logic        qty_zero;
    logic        out_busy;
    logic [1:0]  cmd;
  } sts_t;

endpackage

FILE: rtl/potb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_if: valid/ready channel
// carries one word of a payload type from source to sink
// ----------------------------------------------------------------------------
interface potb_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/potb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_ctrl: request sequencer
// steps each request through scan, fill or modify, rest and acknowledge phases
// ----------------------------------------------------------------------------
module potb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  potb_pkg::sts_t  sts_i,
  output potb_pkg::ctl_t  ctl_o
);
  import potb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_ACK  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.cmd == CMD_INSERT && sts_i.qty_zero) begin
          state_d = S_ACK;
        end else begin
          ctl_o.take_ids   = (sts_i.cmd == CMD_INSERT);
          ctl_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_DEC;
      end
      S_DEC: begin
        if (sts_i.cmd != CMD_INSERT) begin
          ctl_o.modify = 1'b1;
          state_d = S_ACK;
        end else if (!sts_i.qty_zero && sts_i.best_found) begin
          if (!sts_i.out_busy) begin
            ctl_o.fill       = 1'b1;
            ctl_o.scan_start = 1'b1;
            state_d = S_SCAN;
          end
        end else begin
          ctl_o.rest = !sts_i.qty_zero && sts_i.free_found;
          state_d = S_ACK;
        end
      end
      S_ACK: begin
        if (!sts_i.out_busy) begin
          ctl_o.ack = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/potb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_dp: book storage and matching datapath
// two side tables, one-slot-per-cycle scanner, counters and output register
// ----------------------------------------------------------------------------
module potb_dp #(
  parameter int unsigned SideDepth = potb_pkg::SideDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  potb_pkg::req_t  req_i,
  input  potb_pkg::ctl_t  ctl_i,
  output potb_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output potb_pkg::rsp_t  out_data_o
);
  import potb_pkg::*;

  localparam int unsigned IW = $clog2(SideDepth);

  // side 1 buy, side 0 sell; memories read one slot per cycle
  logic [31:0] ident_m [2][SideDepth];
  logic [31:0] limit_m [2][SideDepth];
  logic [31:0] amount_m[2][SideDepth];
  logic [63:0] arr_m   [2][SideDepth];
  logic [SideDepth-1:0] valid_q [2];

  req_t        req_q;
  logic [31:0] qty_q;
  logic [31:0] id_q, next_id_q;
  logic [63:0] ts_q, next_stamp_q;

  logic [IW:0]   idx_q;
  logic          rd_v_q;
  logic [IW-1:0] rd_idx_q;
  logic [31:0]   rd_id_q[2], rd_lim_q[2], rd_amt_q[2];
  logic [63:0]   rd_arr_q[2];
  logic          rd_val_q[2];

  logic          best_f_q, free_f_q, loc_f_q, loc_side_q;
  logic [IW-1:0] best_i_q, free_i_q, loc_i_q;
  logic [31:0]   best_lim_q, best_amt_q, best_id_q, loc_amt_q;
  logic [63:0]   best_arr_q;

  logic          out_v_q;
  rsp_t          out_q;

  logic opp, own;
  assign opp = !req_q.is_buy;
  assign own = req_q.is_buy;

  logic idx_left;
  assign idx_left = (idx_q < (IW+1)'(SideDepth));

  logic scan_active;
  assign scan_active = ctl_i.scan_step && idx_left;

  // memory reads
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 2; s++) begin
      rd_id_q[s]  <= ident_m[s][idx_q[IW-1:0]];
      rd_lim_q[s] <= limit_m[s][idx_q[IW-1:0]];
      rd_amt_q[s] <= amount_m[s][idx_q[IW-1:0]];
      rd_arr_q[s] <= arr_m[s][idx_q[IW-1:0]];
      rd_val_q[s] <= valid_q[s][idx_q[IW-1:0]];
    end
    rd_idx_q <= idx_q[IW-1:0];
  end

  // candidate evaluation on registered read data
  logic elig, better, is_free, loc_hit_s, loc_hit_b;
  always_comb begin
    elig = rd_val_q[opp] &&
           (opp ? !(rd_lim_q[opp] < req_q.price) : !(rd_lim_q[opp] > req_q.price));
    if (!best_f_q) better = 1'b1;
    else if (rd_lim_q[opp] != best_lim_q)
      better = opp ? (rd_lim_q[opp] > best_lim_q) : (rd_lim_q[opp] < best_lim_q);
    else better = rd_arr_q[opp] < best_arr_q;
    is_free   = !rd_val_q[own];
    loc_hit_b = rd_val_q[1] && rd_id_q[1] == req_q.order_id;
    loc_hit_s = rd_val_q[0] && rd_id_q[0] == req_q.order_id;
  end

  logic [31:0] fill_amt;
  assign fill_amt = (qty_q < best_amt_q) ? qty_q : best_amt_q;

  // next output word: trade or acknowledgement
  rsp_t ack_w, trade_w, out_d;
  logic out_v_d;
  always_comb begin
    ack_w = '0;
    ack_w.last = 1'b1;
    if (req_q.cmd == CMD_INSERT) begin
      if (req_q.qty == 32'd0) ack_w.status = ST_ZERO_QTY;
      else begin
        ack_w.stamp       = ts_q;
        ack_w.assigned_id = id_q;
        if (qty_q != 32'd0 && !free_f_q) ack_w.status = ST_FULL;
        else ack_w.remaining_qty = qty_q;
      end
    end else if (!loc_f_q || (req_q.cmd != CMD_CANCEL && req_q.cmd != CMD_REDUCE))
      ack_w.status = ST_NOT_FOUND;
    else if (req_q.cmd == CMD_REDUCE && req_q.qty >= loc_amt_q)
      ack_w.status = ST_NOT_RED;

    trade_w = '{is_trade: 1'b1,
                buyer_id: req_q.is_buy ? id_q : best_id_q,
                seller_id: req_q.is_buy ? best_id_q : id_q,
                trade_price: best_lim_q, trade_qty: fill_amt,
                stamp: next_stamp_q, assigned_id: 32'd0,
                remaining_qty: 32'd0, status: ST_OK, last: 1'b0};

    out_v_d = out_v_q && !out_ready_i;
    out_d   = out_q;
    if (ctl_i.fill) begin
      out_v_d = 1'b1;
      out_d   = trade_w;
    end
    if (ctl_i.ack) begin
      out_v_d = 1'b1;
      out_d   = ack_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0]   <= '0;
      valid_q[1]   <= '0;
      next_id_q    <= 32'd1;
      next_stamp_q <= 64'd1;
      idx_q        <= '0;
      rd_v_q       <= 1'b0;
      best_f_q     <= 1'b0;
      free_f_q     <= 1'b0;
      loc_f_q      <= 1'b0;
      out_v_q      <= 1'b0;
      out_q        <= '0;
    end else begin
      out_v_q <= out_v_d;
      out_q   <= out_d;
      if (ctl_i.load) begin
        req_q <= req_i;
        qty_q <= req_i.qty;
      end
      if (ctl_i.take_ids) begin
        id_q         <= next_id_q;
        ts_q         <= next_stamp_q;
        next_id_q    <= next_id_q + 32'd1;
        next_stamp_q <= next_stamp_q + 64'd1;
      end
      if (ctl_i.scan_start) begin
        idx_q    <= '0;
        rd_v_q   <= 1'b0;
        best_f_q <= 1'b0;
        free_f_q <= 1'b0;
        loc_f_q  <= 1'b0;
      end else if (ctl_i.scan_step) begin
        rd_v_q <= scan_active;
        if (scan_active) idx_q <= idx_q + 1'b1;
        if (rd_v_q) begin
          if (elig && better) begin
            best_f_q   <= 1'b1;
            best_i_q   <= rd_idx_q;
            best_lim_q <= rd_lim_q[opp];
            best_amt_q <= rd_amt_q[opp];
            best_id_q  <= rd_id_q[opp];
            best_arr_q <= rd_arr_q[opp];
          end
          if (is_free && !free_f_q) begin
            free_f_q <= 1'b1;
            free_i_q <= rd_idx_q;
          end
          // buy side wins over any sell side hit, each side first slot first
          if (loc_hit_b && !(loc_f_q && loc_side_q)) begin
            loc_f_q    <= 1'b1;
            loc_side_q <= 1'b1;
            loc_i_q    <= rd_idx_q;
            loc_amt_q  <= rd_amt_q[1];
          end else if (loc_hit_s && !loc_f_q) begin
            loc_f_q    <= 1'b1;
            loc_side_q <= 1'b0;
            loc_i_q    <= rd_idx_q;
            loc_amt_q  <= rd_amt_q[0];
          end
        end
      end
      if (ctl_i.fill) begin
        qty_q <= qty_q - fill_amt;
        if (best_amt_q == fill_amt) valid_q[opp][best_i_q] <= 1'b0;
        next_stamp_q <= next_stamp_q + 64'd1;
      end
      if (ctl_i.rest) valid_q[own][free_i_q] <= 1'b1;
      if (ctl_i.modify && loc_f_q) begin
        if (req_q.cmd == CMD_CANCEL ||
            (req_q.cmd == CMD_REDUCE && req_q.qty == 32'd0 && loc_amt_q != 32'd0))
          valid_q[loc_side_q][loc_i_q] <= 1'b0;
      end
    end
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (ctl_i.fill) amount_m[opp][best_i_q] <= best_amt_q - fill_amt;
    if (ctl_i.rest) begin
      ident_m[own][free_i_q]  <= id_q;
      limit_m[own][free_i_q]  <= req_q.price;
      amount_m[own][free_i_q] <= qty_q;
      arr_m[own][free_i_q]    <= ts_q;
    end
    if (ctl_i.modify && loc_f_q && req_q.cmd == CMD_REDUCE && req_q.qty < loc_amt_q)
      amount_m[loc_side_q][loc_i_q] <= req_q.qty;
  end

  always_comb begin
    sts_o.scan_done  = !idx_left && !rd_v_q;
    sts_o.best_found = best_f_q;
    sts_o.free_found = free_f_q;
    sts_o.id_found   = loc_f_q;
    sts_o.qty_zero   = (qty_q == 32'd0);
    sts_o.out_busy   = out_v_q && !out_ready_i;
    sts_o.cmd        = req_q.cmd;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule

FILE: rtl/price_time_order_book_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_time_order_book_matcher_top: limit order book with price-time matching
// one request word in, trade words then one acknowledgement word marked last
// ----------------------------------------------------------------------------
// Each request is handled alone. The book side tables are scanned one slot per
// cycle, both sides in parallel. A cancel, reduce or insert that does not trade
// runs a single scan; an insert runs one more scan per fill. Zero quantity
// inserts skip the scan. Output words sit in a register so the scan goes on
// while the sink stalls, until the next word must be written.
module price_time_order_book_matcher_top #(
  parameter int unsigned SideDepth = potb_pkg::SideDepthDef
) (
  input logic  clk_i,
  input logic  rst_ni,
  potb_if.sink   req_if,
  potb_if.source rsp_if
);
  import potb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer
  potb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid),
    .in_ready_o (req_if.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // book storage and matching
  potb_dp #(.SideDepth(SideDepth)) u_dp (
    .clk_i, .rst_ni,
    .req_i       (req_if.data),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (rsp_if.valid),
    .out_ready_i (rsp_if.ready),
    .out_data_o  (rsp_if.data)
  );
endmodule

FILE: rtl/potb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_checker: port level checks
// word stability, word shape and one request in flight at a time in the matcher
// ----------------------------------------------------------------------------
module potb_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input potb_pkg::rsp_t  out_data_i
);
  import potb_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.last == !out_data_i.is_trade))
    else $error("last flag does not match word kind");
  a_trade_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.is_trade |-> out_data_i.status == ST_OK &&
      out_data_i.trade_qty != 32'd0)
    else $error("bad trade word");
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request taken before acknowledgement");
endmodule

bind price_time_order_book_matcher_top potb_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i  (req_if.valid),
  .in_ready_i  (req_if.ready),
  .out_valid_i (rsp_if.valid),
  .out_ready_i (rsp_if.ready),
  .out_data_i  (rsp_if.data)
);
